/* hdl/dtfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs_pkg
// shared constants, codes and types of the differential temperature fan
// stepper: window geometry, reciprocal for the window average, level and
// relay codes, register indexes and the datapath control bundle
// ----------------------------------------------------------------------------
package dtfs_pkg;

    // averaging window, entries per ring (2 to 64)
    localparam int WINDOW = 10;

    localparam int RAW_W    = 16;
    localparam int SAMPLE_W = 15;
    localparam int THRESH_W = 12;
    localparam int LEVEL_W  = 3;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int WIN_LOG = $clog2(WINDOW);
    localparam int SLOT_W  = (WIN_LOG < 1) ? 1 : WIN_LOG;
    localparam int SUM_W   = SAMPLE_W + WIN_LOG;
    localparam int HOLD_W  = $clog2(WINDOW + 2);

    // floor(sum / WINDOW) == (sum * RECIP) >> RECIP_SHIFT for every sum < 2**SUM_W
    localparam int RECIP_SHIFT = SUM_W + WIN_LOG;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int unsigned RECIP = ((2 ** RECIP_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // fan levels
    localparam logic [LEVEL_W-1:0] LVL_OFF  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_ONE  = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_TWO  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_THREE = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_FULL = 3'd4;

    // capacitor relay patterns, bit 0 low cap, bit 1 high cap
    localparam logic [1:0] CAP_NONE = 2'b00;
    localparam logic [1:0] CAP_LOW  = 2'b01;
    localparam logic [1:0] CAP_HIGH = 2'b10;
    localparam logic [1:0] CAP_BOTH = 2'b11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL4 = 4'd3;

    localparam logic [THRESH_W-1:0] LEVEL1_RST = 12'd16;
    localparam logic [THRESH_W-1:0] LEVEL2_RST = 12'd32;
    localparam logic [THRESH_W-1:0] LEVEL3_RST = 12'd48;
    localparam logic [THRESH_W-1:0] LEVEL4_RST = 12'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM_A,
        ST_DIV_A,
        ST_SUM_B,
        ST_DIV_B,
        ST_EVAL,
        ST_DONE
    } seq_state_t;

    // sequencer to datapath control
    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_slot;
        logic [SLOT_W-1:0] rd_idx;
        logic              acc_clr;
        logic              acc_add;
        logic              sel_b;
        logic              div_a;
        logic              div_b;
    } dp_ctrl_t;

endpackage
`default_nettype wire

/* hdl/dtfs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs channel interfaces
// valid/ready channels for sample pairs, result items and register writes
// ----------------------------------------------------------------------------

// sample pair channel
interface dtfs_in_if;
    import dtfs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [RAW_W-1:0]   sample_a;
    logic signed [RAW_W-1:0]   sample_b;
    modport source (output valid, output sample_a, output sample_b, input ready);
    modport sink   (input valid, input sample_a, input sample_b, output ready);
endinterface

// result channel
interface dtfs_out_if;
    import dtfs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [LEVEL_W-1:0]    fan_level;
    logic                  level_changed;
    logic                  compared;
    logic [SAMPLE_W-1:0]   average_difference;
    logic                  relay_low_cap;
    logic                  relay_high_cap;
    logic                  main_relay;
    modport source (output valid, output fan_level, output level_changed,
                    output compared, output average_difference,
                    output relay_low_cap, output relay_high_cap,
                    output main_relay, input ready);
    modport sink   (input valid, input fan_level, input level_changed,
                    input compared, input average_difference,
                    input relay_low_cap, input relay_high_cap,
                    input main_relay, output ready);
endinterface

// register write channel
interface dtfs_cfg_if;
    import dtfs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/differential_temp_fan_stepper_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// differential_temp_fan_stepper_core
// fan level stepper driven by the difference of two windowed temperature
// averages, with hold-off between level changes and relay drive outputs
// ----------------------------------------------------------------------------
// sequence: a pair with the hold-off running goes straight to the done state and is
//   then offered on status from the output register; a pair that triggers a comparison
//   first sums ring a, divides, sums ring b, divides and evaluates: one accumulator add
//   per ring entry, one multiply per ring; no new pair is taken until the status is loaded
// reset: rst_n asynchronous, active low; rings cleared, hold-off at one,
//   level off, relays off, thresholds at 16, 32, 48, 64
module differential_temp_fan_stepper_core (
    input  wire logic clk,
    input  wire logic rst_n,
    dtfs_in_if.sink    sensor,
    dtfs_out_if.source status,
    dtfs_cfg_if.sink   cfg
);
    import dtfs_pkg::*;

    seq_state_t          state_reg;
    seq_state_t          state_next;
    dp_ctrl_t            ctrl;
    logic [SAMPLE_W-1:0] avg_diff;

    logic [THRESH_W-1:0] thr1_reg;
    logic [THRESH_W-1:0] thr2_reg;
    logic [THRESH_W-1:0] thr3_reg;
    logic [THRESH_W-1:0] thr4_reg;

    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   rd_idx_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic [HOLD_W-1:0]   hold_inc;
    logic [HOLD_W-1:0]   hold_step;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LEVEL_W-1:0]  new_level;
    logic [1:0]          cap_reg;
    logic [1:0]          cap_next;

    logic                cmp_reg;
    logic                chg_reg;
    logic [SAMPLE_W-1:0] diff_reg;

    logic                in_fire;
    logic                rd_last;
    logic                out_load;
    logic                level_diff;

    logic                out_valid_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic                out_chg_reg;
    logic                out_cmp_reg;
    logic [SAMPLE_W-1:0] out_diff_reg;
    logic [1:0]          out_cap_reg;
    logic                out_main_reg;

    assign sensor.ready = (state_reg == ST_IDLE);
    assign in_fire      = sensor.valid && sensor.ready;
    assign rd_last      = (rd_idx_reg == SLOT_W'(WINDOW - 1));
    assign out_load     = (state_reg == ST_DONE) && (!out_valid_reg || status.ready);

    // register writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr1_reg <= LEVEL1_RST;
            thr2_reg <= LEVEL2_RST;
            thr3_reg <= LEVEL3_RST;
            thr4_reg <= LEVEL4_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_LEVEL1: thr1_reg <= cfg.data[THRESH_W-1:0];
                CFG_LEVEL2: thr2_reg <= cfg.data[THRESH_W-1:0];
                CFG_LEVEL3: thr3_reg <= cfg.data[THRESH_W-1:0];
                CFG_LEVEL4: thr4_reg <= cfg.data[THRESH_W-1:0];
                default:    ;
            endcase
        end
    end

    // hold-off advance for an incoming pair
    assign hold_inc  = (hold_reg != '0) ? (hold_reg + HOLD_W'(1)) : '0;
    assign hold_step = (hold_inc > HOLD_W'(WINDOW)) ? '0 : hold_inc;

    // level selection, highest threshold first
    always_comb
    begin
        if (SAMPLE_W'(thr4_reg) < avg_diff)
            new_level = LVL_FULL;
        else if (SAMPLE_W'(thr3_reg) < avg_diff)
            new_level = LVL_THREE;
        else if (SAMPLE_W'(thr2_reg) < avg_diff)
            new_level = LVL_TWO;
        else if (SAMPLE_W'(thr1_reg) < avg_diff)
            new_level = LVL_ONE;
        else
            new_level = LVL_OFF;
    end

    assign level_diff = (new_level != level_reg);

    // relay pattern for the new level, level off keeps the caps
    always_comb
    begin
        case (new_level)
            LVL_ONE:   cap_next = CAP_LOW;
            LVL_TWO:   cap_next = CAP_HIGH;
            LVL_THREE: cap_next = CAP_BOTH;
            LVL_FULL:  cap_next = CAP_NONE;
            default:   cap_next = cap_reg;
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = (hold_step == '0) ? ST_SUM_A : ST_DONE;
            end
            ST_SUM_A: if (rd_last) state_next = ST_DIV_A;
            ST_DIV_A: state_next = ST_SUM_B;
            ST_SUM_B: if (rd_last) state_next = ST_DIV_B;
            ST_DIV_B: state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs to the datapath
    always_comb
    begin
        ctrl         = '0;
        ctrl.wr_slot = slot_reg;
        ctrl.rd_idx  = rd_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.wr_en   = in_fire;
                ctrl.acc_clr = 1'b1;
            end
            ST_SUM_A: ctrl.acc_add = 1'b1;
            ST_DIV_A:
            begin
                ctrl.div_a   = 1'b1;
                ctrl.acc_clr = 1'b1;
            end
            ST_SUM_B:
            begin
                ctrl.acc_add = 1'b1;
                ctrl.sel_b   = 1'b1;
            end
            ST_DIV_B: ctrl.div_b = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ring read index during the sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_idx_reg <= '0;
        else if ((state_reg == ST_SUM_A) || (state_reg == ST_SUM_B))
            rd_idx_reg <= rd_last ? '0 : (rd_idx_reg + SLOT_W'(1));
        else
            rd_idx_reg <= '0;
    end

    // write slot, hold-off, level and relay state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            hold_reg  <= HOLD_W'(1);
            level_reg <= LVL_OFF;
            cap_reg   <= CAP_NONE;
            cmp_reg   <= 1'b0;
            chg_reg   <= 1'b0;
            diff_reg  <= '0;
        end
        else if (in_fire)
        begin
            slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : (slot_reg + SLOT_W'(1));
            hold_reg <= hold_step;
            cmp_reg  <= 1'b0;
            chg_reg  <= 1'b0;
            diff_reg <= '0;
        end
        else if (state_reg == ST_EVAL)
        begin
            cmp_reg  <= 1'b1;
            chg_reg  <= level_diff;
            diff_reg <= avg_diff;
            if (level_diff)
            begin
                level_reg <= new_level;
                hold_reg  <= HOLD_W'(1);
                cap_reg   <= cap_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (status.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_level_reg <= level_reg;
            out_chg_reg   <= chg_reg;
            out_cmp_reg   <= cmp_reg;
            out_diff_reg  <= diff_reg;
            out_cap_reg   <= cap_reg;
            out_main_reg  <= (level_reg != LVL_OFF);
        end
    end

    assign status.valid              = out_valid_reg;
    assign status.fan_level          = out_level_reg;
    assign status.level_changed      = out_chg_reg;
    assign status.compared           = out_cmp_reg;
    assign status.average_difference = out_diff_reg;
    assign status.relay_low_cap      = out_cap_reg[0];
    assign status.relay_high_cap     = out_cap_reg[1];
    assign status.main_relay         = out_main_reg;

    dtfs_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .sample_a (sensor.sample_a),
        .sample_b (sensor.sample_b),
        .avg_diff (avg_diff)
    );

    // hold-off never runs past the window
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg <= HOLD_W'(WINDOW))
        else $error("hold-off counter beyond window");

    // a level change restarts the hold-off
    a_hold_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) && level_diff |=> (hold_reg == HOLD_W'(1)))
        else $error("hold-off not restarted on level change");

    // comparisons start only from an expired hold-off
    a_sum_entry: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (hold_step != '0) |=> (state_reg == ST_DONE))
        else $error("comparison started with hold-off running");

    // main relay follows the level in every transaction
    a_main_relay: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid |-> (status.main_relay == (status.fan_level != LVL_OFF)))
        else $error("main relay disagrees with level");

    // no change and no difference without a comparison
    a_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && !status.compared |->
            !status.level_changed && (status.average_difference == '0))
        else $error("result fields set without comparison");

endmodule
`default_nettype wire

/* hdl/dtfs_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtfs_datapath
// sample rings, shared accumulator adder and shared reciprocal multiplier
// that turn each ring sum into its truncated average, plus the absolute
// difference of the two averages
// ----------------------------------------------------------------------------
module dtfs_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dtfs_pkg::dp_ctrl_t                ctrl,
    input  wire logic signed [dtfs_pkg::RAW_W-1:0] sample_a,
    input  wire logic signed [dtfs_pkg::RAW_W-1:0] sample_b,
    output logic [dtfs_pkg::SAMPLE_W-1:0]          avg_diff
);
    import dtfs_pkg::*;

    logic [SAMPLE_W-1:0] ring_a_reg [WINDOW];
    logic [SAMPLE_W-1:0] ring_b_reg [WINDOW];
    logic [SAMPLE_W-1:0] clamp_a;
    logic [SAMPLE_W-1:0] clamp_b;
    logic [SAMPLE_W-1:0] operand;
    logic [SUM_W-1:0]    acc_reg;
    logic [SUM_W-1:0]    acc_next;
    logic [PROD_W-1:0]   product;
    logic [SAMPLE_W-1:0] avg_a_reg;
    logic [SAMPLE_W-1:0] avg_b_reg;

    // negative readings clamp to zero
    assign clamp_a = sample_a[RAW_W-1] ? '0 : sample_a[SAMPLE_W-1:0];
    assign clamp_b = sample_b[RAW_W-1] ? '0 : sample_b[SAMPLE_W-1:0];

    // ring storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_a_reg[i] <= '0;
                ring_b_reg[i] <= '0;
            end
        end
        else if (ctrl.wr_en)
        begin
            ring_a_reg[ctrl.wr_slot] <= clamp_a;
            ring_b_reg[ctrl.wr_slot] <= clamp_b;
        end
    end

    // shared accumulator, one ring entry per cycle
    assign operand = ctrl.sel_b ? ring_b_reg[ctrl.rd_idx] : ring_a_reg[ctrl.rd_idx];

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
            acc_next = '0;
        else if (ctrl.acc_add)
            acc_next = acc_reg + SUM_W'(operand);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            acc_reg <= '0;
        else
            acc_reg <= acc_next;
    end

    // shared reciprocal multiply, divides the sum by the window
    assign product = PROD_W'(acc_reg) * PROD_W'(RECIP_W'(RECIP));

    always_ff @(posedge clk)
    begin
        if (ctrl.div_a)
            avg_a_reg <= product[RECIP_SHIFT +: SAMPLE_W];
        if (ctrl.div_b)
            avg_b_reg <= product[RECIP_SHIFT +: SAMPLE_W];
    end

    // absolute difference of the averages
    assign avg_diff = (avg_a_reg >= avg_b_reg) ? (avg_a_reg - avg_b_reg)
                                               : (avg_b_reg - avg_a_reg);

endmodule
`default_nettype wire

/* tb/fan_status_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fan_status_checker
// watches the sample, status and register write channels of the fan stepper,
// keeps its own copy of the rings, hold-off, level and relay state, predicts
// the status of every accepted sample pair and compares each returned status
// transaction field by field in order
// ----------------------------------------------------------------------------
module fan_status_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    dtfs_in_if        sensor,
    dtfs_out_if       status,
    dtfs_cfg_if       cfg,
    output int        fail_count,
    output int        outstanding
);
    import dtfs_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0]  fan_level;
        logic                level_changed;
        logic                compared;
        logic [SAMPLE_W-1:0] average_difference;
        logic                relay_low_cap;
        logic                relay_high_cap;
        logic                main_relay;
    } fan_status_t;

    // shadow of the block state
    logic [THRESH_W-1:0] thresh [4];
    logic [SAMPLE_W-1:0] ring_a [WINDOW];
    logic [SAMPLE_W-1:0] ring_b [WINDOW];
    logic [SLOT_W-1:0]   slot;
    logic [HOLD_W-1:0]   holdoff;
    logic [LEVEL_W-1:0]  level;
    logic [1:0]          caps;

    fan_status_t pending_status_q [$];
    int          errors;

    function automatic logic [SAMPLE_W-1:0] clamp_reading(input logic [RAW_W-1:0] raw);
        return raw[RAW_W-1] ? '0 : raw[SAMPLE_W-1:0];
    endfunction

    // one sample pair through the stepper
    task step_fan(input logic [RAW_W-1:0] raw_a, input logic [RAW_W-1:0] raw_b,
                  output fan_status_t res);
        logic [SUM_W-1:0]    sum_a;
        logic [SUM_W-1:0]    sum_b;
        logic [SAMPLE_W-1:0] avg_a;
        logic [SAMPLE_W-1:0] avg_b;
        logic [LEVEL_W-1:0]  lvl;
        res = '0;
        if (holdoff != 0)
            holdoff = holdoff + 1'b1;
        if (holdoff > WINDOW)
            holdoff = '0;

        ring_a[slot] = clamp_reading(raw_a);
        ring_b[slot] = clamp_reading(raw_b);
        slot = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;

        if (holdoff == 0)
        begin
            sum_a = '0;
            sum_b = '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                sum_a = sum_a + ring_a[i];
                sum_b = sum_b + ring_b[i];
            end
            avg_a = SAMPLE_W'(sum_a / WINDOW);
            avg_b = SAMPLE_W'(sum_b / WINDOW);
            res.compared = 1'b1;
            res.average_difference = (avg_a >= avg_b) ? avg_a - avg_b : avg_b - avg_a;

            // priority from full level down
            if (res.average_difference > thresh[3])
                lvl = LVL_FULL;
            else if (res.average_difference > thresh[2])
                lvl = LVL_THREE;
            else if (res.average_difference > thresh[1])
                lvl = LVL_TWO;
            else if (res.average_difference > thresh[0])
                lvl = LVL_ONE;
            else
                lvl = LVL_OFF;

            if (lvl != level)
            begin
                res.level_changed = 1'b1;
                level = lvl;
                holdoff = HOLD_W'(1);
                case (lvl)
                    LVL_ONE:   caps = CAP_LOW;
                    LVL_TWO:   caps = CAP_HIGH;
                    LVL_THREE: caps = CAP_BOTH;
                    LVL_FULL:  caps = CAP_NONE;
                    default:   caps = caps;
                endcase
            end
        end

        res.fan_level      = level;
        res.relay_low_cap  = caps[0];
        res.relay_high_cap = caps[1];
        res.main_relay     = (level != LVL_OFF);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor all three channels
    always @(posedge clk or negedge rst_n)
    begin
        fan_status_t want;
        if (!rst_n)
        begin
            thresh[0] = LEVEL1_RST;
            thresh[1] = LEVEL2_RST;
            thresh[2] = LEVEL3_RST;
            thresh[3] = LEVEL4_RST;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_a[i] = '0;
                ring_b[i] = '0;
            end
            slot    = '0;
            holdoff = HOLD_W'(1);
            level   = LVL_OFF;
            caps    = CAP_NONE;
            pending_status_q.delete();
            errors  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // status transaction against the oldest prediction
            if (status.valid && status.ready)
            begin
                if (pending_status_q.size() == 0)
                begin
                    $display("%0t: status transaction with nothing expected, actual level %0d",
                             $time, status.fan_level);
                    errors++;
                end
                else
                begin
                    want = pending_status_q.pop_front();
                    check_field("fan_level", want.fan_level, status.fan_level);
                    check_field("level_changed", want.level_changed, status.level_changed);
                    check_field("compared", want.compared, status.compared);
                    check_field("average_difference", want.average_difference,
                                status.average_difference);
                    check_field("relay_low_cap", want.relay_low_cap, status.relay_low_cap);
                    check_field("relay_high_cap", want.relay_high_cap, status.relay_high_cap);
                    check_field("main_relay", want.main_relay, status.main_relay);
                end
            end

            // register write, upper data bits dropped, unknown index ignored
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_LEVEL1: thresh[0] = cfg.data[THRESH_W-1:0];
                    CFG_LEVEL2: thresh[1] = cfg.data[THRESH_W-1:0];
                    CFG_LEVEL3: thresh[2] = cfg.data[THRESH_W-1:0];
                    CFG_LEVEL4: thresh[3] = cfg.data[THRESH_W-1:0];
                    default: ;
                endcase
            end

            // sample pair transaction
            if (sensor.valid && sensor.ready)
            begin
                step_fan(sensor.sample_a, sensor.sample_b, want);
                pending_status_q.push_back(want);
            end

            fail_count  <= errors;
            outstanding <= pending_status_q.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// regression for the differential temperature fan stepper: directed extreme
// readings, then bursts of steady sample pairs aimed at the level thresholds
// mixed with negative and fully random readings, over several threshold
// settings, with random stalls on both channels and one long status hold-off
// ----------------------------------------------------------------------------
module testbench;
    import dtfs_pkg::*;

    logic clk;
    logic rst_n;

    dtfs_in_if  sensor_if ();
    dtfs_out_if status_if ();
    dtfs_cfg_if cfg_if ();

    int fail_count;
    int outstanding;
    int sent_count;
    bit smooth;
    int thr_now [4];

    // directed readings: extremes, mixed signs, a settle to equal rings, then a rise on side a
    int dir_a [24] = '{0, 32767, 0, -32768, -1, 32767, -32768, 16384, 21845, 32767,
                       1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000,
                       1030, 1050, 1070, 2000};
    int dir_b [24] = '{0, 0, 32767, -32768, 32767, -1, 0, 16383, 10922, 32767,
                       1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000, 1000,
                       1000, 1000, 1000, 1000};

    differential_temp_fan_stepper_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sensor (sensor_if),
        .status (status_if),
        .cfg    (cfg_if)
    );

    fan_status_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sensor      (sensor_if),
        .status      (status_if),
        .cfg         (cfg_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("differential_temp_fan_stepper_core regression: fail");
        $finish;
    end

    // status receiver with random stalls and one long hold-off
    initial
    begin
        int  stall_left;
        int  r;
        bit  long_done;
        stall_left = 0;
        long_done  = 1'b0;
        status_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!long_done && sent_count >= 400)
            begin
                status_if.ready <= 1'b0;
                repeat (200) @(posedge clk);
                long_done = 1'b1;
            end
            else if (smooth)
                status_if.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                status_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    status_if.ready <= 1'b1;
                else
                begin
                    status_if.ready <= 1'b0;
                    stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                end
            end
        end
    end

    // offer one sample pair and wait for the transaction
    task send_pair(input int a, input int b);
        int gap;
        int r;
        sensor_if.valid    <= 1'b1;
        sensor_if.sample_a <= RAW_W'(a);
        sensor_if.sample_b <= RAW_W'(b);
        @(posedge clk);
        while (!sensor_if.ready)
            @(posedge clk);
        sent_count++;
        r = $urandom_range(0, 99);
        if (smooth || r < 65)
            gap = 0;
        else if (r < 95)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0)
        begin
            sensor_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // register write transaction, valid left high for back to back writes
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        if (idx <= CFG_LEVEL4)
            thr_now[idx] = data[THRESH_W-1:0];
    endtask

    // stop offering and wait until every status has come back
    task drain();
        sensor_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        int burst_left;
        int mode;
        int base;
        int d;
        int a;
        int b;
        int t;
        int v;
        int count;
        bit swap;
        burst_left = 0;
        mode       = 0;
        base       = 0;
        d          = 0;
        swap       = 1'b0;
        sent_count = 0;
        smooth     = 1'b0;
        thr_now[0] = LEVEL1_RST;
        thr_now[1] = LEVEL2_RST;
        thr_now[2] = LEVEL3_RST;
        thr_now[3] = LEVEL4_RST;
        rst_n              <= 1'b0;
        sensor_if.valid    <= 1'b0;
        sensor_if.sample_a <= '0;
        sensor_if.sample_b <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed readings
        for (int i = 0; i < 24; i++)
            send_pair(dir_a[i], dir_b[i]);

        for (int phase = 0; phase < 6; phase++)
        begin
            // new threshold setting while idle
            if (phase > 0)
            begin
                drain();
                case (phase)
                    1:
                    begin
                        // all zero, upper data bits set and dropped
                        write_reg(CFG_LEVEL1, 16'hF000);
                        write_reg(CFG_LEVEL2, 16'h0000);
                        write_reg(CFG_LEVEL3, 16'hA000);
                        write_reg(CFG_LEVEL4, 16'h0000);
                    end
                    2:
                    begin
                        // all at maximum
                        write_reg(CFG_LEVEL1, 16'hFFFF);
                        write_reg(CFG_LEVEL2, 16'h0FFF);
                        write_reg(CFG_LEVEL3, 16'h7FFF);
                        write_reg(CFG_LEVEL4, 16'h0FFF);
                    end
                    3:
                    begin
                        // random ascending
                        v = $urandom_range(0, 150);
                        write_reg(CFG_LEVEL1, 16'(v));
                        v = v + $urandom_range(0, 150);
                        write_reg(CFG_LEVEL2, 16'(v));
                        v = v + $urandom_range(0, 150);
                        write_reg(CFG_LEVEL3, 16'(v));
                        v = v + $urandom_range(0, 150);
                        write_reg(CFG_LEVEL4, 16'(v));
                    end
                    4:
                    begin
                        // thresholds out of order, plus writes to unused indexes
                        write_reg(CFG_LEVEL1, 16'($urandom()));
                        write_reg(CFG_LEVEL2, 16'($urandom_range(0, 4095)));
                        write_reg(CFG_LEVEL3, 16'($urandom_range(0, 300)));
                        write_reg(CFG_LEVEL4, 16'($urandom_range(0, 100)));
                        for (int i = 4; i < 16; i++)
                            write_reg(CFG_IDX_W'(i), 16'($urandom()));
                    end
                    default:
                    begin
                        write_reg(CFG_LEVEL1, 16'(LEVEL1_RST));
                        write_reg(CFG_LEVEL2, 16'(LEVEL2_RST));
                        write_reg(CFG_LEVEL3, 16'(LEVEL3_RST));
                        write_reg(CFG_LEVEL4, 16'(LEVEL4_RST));
                    end
                endcase
                cfg_if.valid <= 1'b0;
                @(posedge clk);
            end
            smooth = (phase == 5);
            count  = (phase == 0) ? 276 : 300;

            for (int n = 0; n < count; n++)
            begin
                // pick the shape of the next burst
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(5, 40);
                    t = $urandom_range(0, 99);
                    mode = (t < 60) ? 0 : (t < 72) ? 1 : (t < 84) ? 2 : 3;
                    base = $urandom_range(0, 28000);
                    swap = $urandom_range(0, 1);
                    if (mode == 3)
                        d = $urandom_range(0, 3);
                    else if ($urandom_range(0, 3) == 0)
                        d = $urandom_range(0, 300);
                    else
                    begin
                        d = thr_now[$urandom_range(0, 3)] + $urandom_range(0, 8) - 4;
                        if (d < 0)
                            d = 0;
                    end
                end
                burst_left--;

                case (mode)
                    1:
                    begin
                        a = $urandom_range(0, 65535);
                        b = $urandom_range(0, 65535);
                    end
                    2:
                    begin
                        // negative readings, chosen for each side independently
                        a = ($urandom_range(0, 2) == 0) ? base : -$urandom_range(1, 32768);
                        b = ($urandom_range(0, 2) == 0) ? base : -$urandom_range(1, 32768);
                    end
                    default:
                    begin
                        // steady pair around a chosen difference
                        a = base + d + $urandom_range(0, 2) - 1;
                        b = base + $urandom_range(0, 2) - 1;
                        a = (a > 32767) ? 32767 : (a < 0) ? 0 : a;
                        b = (b > 32767) ? 32767 : (b < 0) ? 0 : b;
                        if (swap)
                        begin
                            v = a;
                            a = b;
                            b = v;
                        end
                    end
                endcase
                send_pair(a, b);
            end
        end

        // wrap up
        drain();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("differential_temp_fan_stepper_core regression: pass");
        else
            $display("differential_temp_fan_stepper_core regression: fail");
        $finish;
    end

endmodule
